@@ sv/tsch_pkg.sv @@
// Shared constants, codes and control/status types for the thread scheduler.
package tsch_pkg;

	// Thread table geometry
	localparam int SLOTS = 16;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = IDX_W + 1;

	// Millisecond-to-tick conversion
	localparam int MS_W = 16;
	localparam int FREQ_W = 32;
	localparam int PROD_W = FREQ_W + MS_W;
	localparam int REM_W = 10;
	localparam logic [REM_W:0] DIVISOR = 11'd1000;
	// Long division by 1000 in 16-bit digits, each digit by reciprocal multiply
	localparam int DIG_W = 16;
	localparam int DIGITS = PROD_W / DIG_W;
	localparam int STEP_W = REM_W + DIG_W;
	localparam int RECIP_W = 27;
	localparam int RECIP_SH = 36;
	localparam int MUL_W = STEP_W + RECIP_W;
	// ceil(2^36 / 1000); exact for every step value below 1000 * 2^16
	localparam logic [RECIP_W-1:0] RECIP = 27'd68719477;

	// Thread states
	localparam logic [2:0] ST_NEW = 3'd0;
	localparam logic [2:0] ST_READY = 3'd1;
	localparam logic [2:0] ST_RUN = 3'd2;
	localparam logic [2:0] ST_BLOCKED = 3'd3;
	localparam logic [2:0] ST_TERM = 3'd4;
	localparam logic [2:0] ST_SUSP_READY = 3'd5;
	localparam logic [2:0] ST_SUSP_WAIT = 3'd6;

	// Commands
	localparam logic [2:0] CMD_TICK = 3'd0;
	localparam logic [2:0] CMD_CONF = 3'd1;
	localparam logic [2:0] CMD_START = 3'd2;
	localparam logic [2:0] CMD_SUSP = 3'd3;
	localparam logic [2:0] CMD_KILL = 3'd4;
	localparam logic [2:0] CMD_SLEEP = 3'd5;
	localparam logic [2:0] CMD_YIELD = 3'd6;
	localparam logic [2:0] CMD_EXIT = 3'd7;

	// Configuration register indexes
	localparam logic [2:0] CFG_EN = 3'd0;
	localparam logic [2:0] CFG_MODE = 3'd1;
	localparam logic [2:0] CFG_QUANT = 3'd2;
	localparam logic [2:0] CFG_FREQ = 3'd3;
	localparam logic [2:0] CFG_COUNT = 3'd4;

	// Scheduling modes
	localparam logic [1:0] MODE_RR = 2'd0;
	localparam logic [1:0] MODE_PRIO = 2'd1;
	localparam logic [1:0] MODE_EDF = 2'd2;

	// Datapath operations
	localparam logic [3:0] OP_NONE = 4'd0;
	localparam logic [3:0] OP_DISP = 4'd1;
	localparam logic [3:0] OP_WAKE = 4'd2;
	localparam logic [3:0] OP_ST_DL = 4'd3;
	localparam logic [3:0] OP_ST_PER = 4'd4;
	localparam logic [3:0] OP_ST_FIN = 4'd5;
	localparam logic [3:0] OP_SLEEP = 4'd6;
	localparam logic [3:0] OP_RR_CHK = 4'd7;
	localparam logic [3:0] OP_RR_PICK = 4'd8;
	localparam logic [3:0] OP_RR_FALL = 4'd9;
	localparam logic [3:0] OP_PR_EVAL = 4'd10;
	localparam logic [3:0] OP_PR_DEM = 4'd11;
	localparam logic [3:0] OP_PR_SEL = 4'd12;
	localparam logic [3:0] OP_OUT = 4'd13;

	// Table address sources
	localparam logic [1:0] ADDR_TGT = 2'd0;
	localparam logic [1:0] ADDR_SCAN = 2'd1;
	localparam logic [1:0] ADDR_CUR = 2'd2;
	localparam logic [1:0] ADDR_BEST = 2'd3;

	// Conversion operand sources
	localparam logic [1:0] CV_DL = 2'd0;
	localparam logic [1:0] CV_PER = 2'd1;
	localparam logic [1:0] CV_DUR = 2'd2;

	typedef struct packed {
		logic latch;
		logic [3:0] op;
		logic [1:0] addr_sel;
		logic [IDX_W-1:0] scan_idx;
		logic first;
		logic cv_start;
		logic [1:0] cv_sel;
	} ctl_t;

	typedef struct packed {
		logic is_start_ok;
		logic tick_go;
		logic sleep_go;
		logic start_hit;
		logic dl_neg;
		logic cv_done;
		logic rr_need;
		logic [IDX_W-1:0] rr_j0;
		logic rr_ready;
		logic [1:0] mode;
		logic [CNT_W-1:0] n;
		logic out_free;
	} stat_t;

endpackage

@@ sv/tsch_conv.sv @@
// Millisecond-to-tick converter: multiply by frequency, then divide by 1000 in three 16-bit digits.
module tsch_conv
	import tsch_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [FREQ_W-1:0] freq,
	input  logic [MS_W-1:0]   ms,
	output logic              done,
	output logic [PROD_W-1:0] quot
);

	localparam int CNT_BITS = $clog2(DIGITS + 1);

	logic [PROD_W-1:0] prod_q;
	logic [REM_W-1:0] rem_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [STEP_W-1:0] step_val;
	logic [MUL_W-1:0] step_prod;
	logic [DIG_W-1:0] qdig;
	logic [STEP_W-1:0] qback;
	logic [STEP_W-1:0] step_rem;

	// One quotient digit: remainder and next digit over 1000 by reciprocal multiply
	assign step_val = {rem_q, prod_q[PROD_W-1 -: DIG_W]};
	assign step_prod = MUL_W'(step_val) * MUL_W'(RECIP);
	assign qdig = step_prod[RECIP_SH +: DIG_W];
	assign qback = STEP_W'(qdig) * STEP_W'(DIVISOR);
	assign step_rem = step_val - qback;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_BITS'(DIGITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial remainder; quotient digits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= PROD_W'(freq) * PROD_W'(ms);
			rem_q <= '0;
		end else if (busy_q) begin
			prod_q <= {prod_q[PROD_W-DIG_W-1:0], qdig};
			rem_q <= step_rem[REM_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = prod_q;

endmodule

@@ sv/tsch_dp.sv @@
// Scheduler datapath: thread table, config registers, item latch and result register.
module tsch_dp
	import tsch_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [2:0]  cmd,
	input  logic [3:0]  tid,
	input  logic [63:0] now,
	input  logic [7:0]  priority_req,
	input  logic signed [16:0] rel_dl_ms,
	input  logic [15:0] restart_ms,
	input  logic signed [16:0] run_limit,
	input  logic [15:0] duration_ms,
	input  ctl_t        ctl,
	output stat_t       st,
	input  logic        out_ready,
	output logic        out_valid,
	output logic        running_valid,
	output logic [3:0]  running_thread,
	output logic        switched,
	output logic        accepted,
	output logic [2:0]  thread_status
);

	// Config registers
	logic en_q;
	logic [1:0] mode_q;
	logic [31:0] quant_q;
	logic [31:0] freq_q;
	logic [4:0] count_q;

	// Latched item
	logic [2:0] it_cmd_q;
	logic [IDX_W-1:0] it_id_q;
	logic [63:0] it_now_q;
	logic [7:0] it_prio_q;
	logic [16:0] it_dl_q;
	logic [15:0] it_per_q;
	logic [16:0] it_tgt_q;
	logic [15:0] it_dur_q;
	logic old_pres_q;
	logic [IDX_W-1:0] old_cur_q;

	// Thread table
	logic [2:0] st_q [SLOTS];
	logic [7:0] prio_q [SLOTS];
	logic [16:0] dloff_q [SLOTS];
	logic [15:0] per_q [SLOTS];
	logic [16:0] tgt_q [SLOTS];
	logic [15:0] runs_q [SLOTS];
	logic [63:0] wake_q [SLOTS];
	logic [63:0] nxt_q [SLOTS];
	logic [63:0] abs_q [SLOTS];

	// Scheduler state
	logic pres_q;
	logic [IDX_W-1:0] cur_q;
	logic [63:0] slice_q;
	logic [IDX_W-1:0] best_q;
	logic [63:0] best_key_q;
	logic found_q;
	logic acc_q;

	// Result register
	logic out_valid_q;
	logic rv_q;
	logic [3:0] rt_q;
	logic sw_q;
	logic acc_out_q;
	logic [2:0] ts_q;

	logic [CNT_W-1:0] n;
	logic by_id, by_id_ok, tick_go, sleep_go, cur_go;
	logic [IDX_W-1:0] addr;
	logic [2:0] s;
	logic [15:0] runs;
	logic [16:0] tgt;
	logic [MS_W-1:0] cv_ms;
	logic cv_done;
	logic [PROD_W-1:0] quot;
	logic [63:0] sum;
	logic [63:0] elapsed;
	logic expired;
	logic wake_hit, start_hit, dl_neg, tgt_ok;
	logic [IDX_W-1:0] rr_base;
	logic [CNT_W-1:0] rr_inc;
	logic eligible, found_eff, take;
	logic [63:0] key;
	logic out_free;
	logic [2:0] status;

	logic st_we;
	logic [2:0] st_wd;
	logic ent_we, tgt_we, runs_we, wake_we, nxt_we, abs_we;
	logic [16:0] tgt_wd;
	logic [15:0] runs_wd;
	logic [63:0] abs_wd;
	logic cur_we, slice_we;

	// Command classification
	assign n = (count_q > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : count_q;
	assign by_id = (it_cmd_q == CMD_CONF) || (it_cmd_q == CMD_START) ||
		(it_cmd_q == CMD_SUSP) || (it_cmd_q == CMD_KILL);
	assign by_id_ok = by_id && ({1'b0, it_id_q} < n);
	assign tick_go = (it_cmd_q == CMD_TICK) && (n != '0) && en_q;
	assign sleep_go = (it_cmd_q == CMD_SLEEP) && pres_q && en_q;
	assign cur_go = ((it_cmd_q == CMD_YIELD) || (it_cmd_q == CMD_EXIT)) && pres_q;

	// Table address
	always_comb begin
		unique case (ctl.addr_sel)
			ADDR_TGT:  addr = by_id ? it_id_q : cur_q;
			ADDR_SCAN: addr = ctl.scan_idx;
			ADDR_CUR:  addr = cur_q;
			ADDR_BEST: addr = best_q;
		endcase
	end

	assign s = st_q[addr];
	assign runs = runs_q[addr];
	assign tgt = tgt_q[addr];
	assign dl_neg = dloff_q[addr][16];

	// Conversion operand
	always_comb begin
		case (ctl.cv_sel)
			CV_DL:   cv_ms = dloff_q[addr][15:0];
			CV_PER:  cv_ms = per_q[addr];
			default: cv_ms = it_dur_q;
		endcase
	end

	tsch_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.cv_start),
		.freq   (freq_q),
		.ms     (cv_ms),
		.done   (cv_done),
		.quot   (quot)
	);

	// Time arithmetic
	assign sum = it_now_q + {{(64-PROD_W){1'b0}}, quot};
	assign elapsed = it_now_q - slice_q;
	assign expired = elapsed >= {32'b0, quant_q};

	// Wake and restart tests for the addressed entry
	assign wake_hit = (s == ST_BLOCKED) && (it_now_q >= wake_q[addr]);
	assign tgt_ok = (tgt == 17'h1FFFF) || ($signed({2'b00, runs}) < $signed({tgt[16], tgt}));
	assign start_hit = ((s == ST_TERM) || (s == ST_NEW)) && !(pres_q && (cur_q == addr)) &&
		tgt_ok && (it_now_q >= nxt_q[addr]);

	// Round robin start point
	assign rr_base = (pres_q && ({1'b0, cur_q} < n)) ? cur_q : IDX_W'(n - 1'b1);
	assign rr_inc = {1'b0, rr_base} + 1'b1;

	// Priority or deadline comparison
	assign key = (mode_q == MODE_PRIO) ? {56'b0, prio_q[addr]} : abs_q[addr];
	assign eligible = (s == ST_READY) || (s == ST_RUN);
	assign found_eff = ctl.first ? 1'b0 : found_q;
	assign take = eligible && (!found_eff || (key < best_key_q));

	assign out_free = !out_valid_q || out_ready;

	// Reported state of the addressed thread
	always_comb begin
		if (by_id)
			status = acc_q ? s : 3'd0;
		else
			status = pres_q ? s : 3'd0;
	end

	// Table write decode
	always_comb begin
		st_we = 1'b0;
		st_wd = s;
		ent_we = 1'b0;
		tgt_we = 1'b0;
		tgt_wd = it_tgt_q;
		runs_we = 1'b0;
		runs_wd = '0;
		wake_we = 1'b0;
		nxt_we = 1'b0;
		abs_we = 1'b0;
		abs_wd = sum;
		cur_we = 1'b0;
		slice_we = 1'b0;
		case (ctl.op)
			OP_DISP: begin
				if (by_id_ok) begin
					case (it_cmd_q)
						CMD_CONF: begin
							ent_we = 1'b1;
							tgt_we = 1'b1;
							runs_we = 1'b1;
						end
						CMD_SUSP: begin
							st_we = 1'b1;
							st_wd = (s == ST_BLOCKED) ? ST_SUSP_WAIT : ST_SUSP_READY;
						end
						CMD_KILL: begin
							tgt_we = 1'b1;
							tgt_wd = '0;
							runs_we = 1'b1;
							st_we = 1'b1;
							st_wd = ST_TERM;
						end
						default: ;
					endcase
				end else if (cur_go) begin
					if (it_cmd_q == CMD_EXIT) begin
						st_we = 1'b1;
						st_wd = ST_TERM;
					end else if (s == ST_RUN) begin
						st_we = 1'b1;
						st_wd = ST_READY;
					end
				end
			end
			OP_WAKE: begin
				if (wake_hit) begin
					st_we = 1'b1;
					st_wd = ST_READY;
				end
			end
			OP_ST_DL: begin
				abs_we = 1'b1;
				abs_wd = dl_neg ? '1 : sum;
			end
			OP_ST_PER: nxt_we = 1'b1;
			OP_ST_FIN: begin
				st_we = 1'b1;
				st_wd = ST_READY;
				if (((s == ST_NEW) || (s == ST_TERM)) && (runs != 16'hFFFF)) begin
					runs_we = 1'b1;
					runs_wd = runs + 1'b1;
				end
			end
			OP_SLEEP: begin
				wake_we = 1'b1;
				st_we = 1'b1;
				st_wd = ST_BLOCKED;
			end
			OP_RR_CHK: begin
				if (pres_q && (s == ST_RUN) && expired) begin
					st_we = 1'b1;
					st_wd = ST_READY;
				end
			end
			OP_RR_PICK: begin
				if (s == ST_READY) begin
					st_we = 1'b1;
					st_wd = ST_RUN;
					cur_we = 1'b1;
					slice_we = 1'b1;
				end
			end
			OP_RR_FALL: begin
				if (pres_q && (s == ST_READY)) begin
					st_we = 1'b1;
					st_wd = ST_RUN;
					slice_we = 1'b1;
				end
			end
			OP_PR_DEM: begin
				if (found_q && pres_q && (cur_q != best_q) && (s == ST_RUN)) begin
					st_we = 1'b1;
					st_wd = ST_READY;
				end
			end
			OP_PR_SEL: begin
				if (found_q) begin
					st_we = 1'b1;
					st_wd = ST_RUN;
					cur_we = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
			mode_q <= MODE_RR;
			quant_q <= 32'd480000;
			freq_q <= 32'd24000000;
			count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_EN:    en_q <= cfg_data[0];
				CFG_MODE:  mode_q <= cfg_data[1:0];
				CFG_QUANT: quant_q <= cfg_data;
				CFG_FREQ:  freq_q <= cfg_data;
				CFG_COUNT: count_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Item latch
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			it_cmd_q <= cmd;
			it_id_q <= tid;
			it_now_q <= now;
			it_prio_q <= priority_req;
			it_dl_q <= rel_dl_ms;
			it_per_q <= restart_ms;
			it_tgt_q <= run_limit;
			it_dur_q <= duration_ms;
			old_pres_q <= pres_q;
			old_cur_q <= cur_q;
		end
	end

	// Thread table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				st_q[i] <= ST_NEW;
				prio_q[i] <= 8'd128;
				dloff_q[i] <= '1;
				per_q[i] <= '0;
				tgt_q[i] <= '0;
				runs_q[i] <= '0;
				wake_q[i] <= '0;
				nxt_q[i] <= '0;
				abs_q[i] <= '0;
			end
		end else begin
			if (st_we)
				st_q[addr] <= st_wd;
			if (ent_we) begin
				prio_q[addr] <= it_prio_q;
				dloff_q[addr] <= it_dl_q;
				per_q[addr] <= it_per_q;
			end
			if (tgt_we)
				tgt_q[addr] <= tgt_wd;
			if (runs_we)
				runs_q[addr] <= runs_wd;
			if (wake_we)
				wake_q[addr] <= sum;
			if (nxt_we)
				nxt_q[addr] <= sum;
			if (abs_we)
				abs_q[addr] <= abs_wd;
		end
	end

	// Current thread, slice start and selection tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pres_q <= 1'b0;
			cur_q <= '0;
			slice_q <= '0;
			found_q <= 1'b0;
			acc_q <= 1'b0;
		end else begin
			if (cur_we) begin
				pres_q <= 1'b1;
				cur_q <= addr;
			end
			if (slice_we)
				slice_q <= it_now_q;
			if (ctl.op == OP_PR_EVAL)
				found_q <= found_eff | eligible;
			if (ctl.op == OP_DISP)
				acc_q <= by_id_ok | tick_go | sleep_go | cur_go;
		end
	end

	always_ff @(posedge clk) begin
		if ((ctl.op == OP_PR_EVAL) && take) begin
			best_q <= addr;
			best_key_q <= key;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if ((ctl.op == OP_OUT) && out_free)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if ((ctl.op == OP_OUT) && out_free) begin
			rv_q <= pres_q;
			rt_q <= pres_q ? 4'(cur_q) : 4'd0;
			sw_q <= (pres_q != old_pres_q) || (pres_q && (cur_q != old_cur_q));
			acc_out_q <= acc_q;
			ts_q <= status;
		end
	end

	// Status to the controller
	assign st.is_start_ok = by_id_ok && (it_cmd_q == CMD_START);
	assign st.tick_go = tick_go;
	assign st.sleep_go = sleep_go;
	assign st.start_hit = start_hit;
	assign st.dl_neg = dl_neg;
	assign st.cv_done = cv_done;
	assign st.rr_need = !pres_q || (s != ST_RUN) || expired;
	assign st.rr_j0 = (rr_inc == n) ? '0 : rr_inc[IDX_W-1:0];
	assign st.rr_ready = (s == ST_READY);
	assign st.mode = mode_q;
	assign st.n = n;
	assign st.out_free = out_free;

	assign out_valid = out_valid_q;
	assign running_valid = rv_q;
	assign running_thread = rt_q;
	assign switched = sw_q;
	assign accepted = acc_out_q;
	assign thread_status = ts_q;

endmodule

@@ sv/tsch_ctrl.sv @@
// Scheduler controller: sequences dispatch, wake pass, thread start and selection.
module tsch_ctrl
	import tsch_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output ctl_t  ctl
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DISP = 4'd1;
	localparam logic [3:0] S_WAKE = 4'd2;
	localparam logic [3:0] S_DL = 4'd3;
	localparam logic [3:0] S_DL_W = 4'd4;
	localparam logic [3:0] S_PER = 4'd5;
	localparam logic [3:0] S_PER_W = 4'd6;
	localparam logic [3:0] S_FIN = 4'd7;
	localparam logic [3:0] S_SLP_W = 4'd8;
	localparam logic [3:0] S_RR_CHK = 4'd9;
	localparam logic [3:0] S_RR_SCAN = 4'd10;
	localparam logic [3:0] S_RR_FALL = 4'd11;
	localparam logic [3:0] S_PR_SCAN = 4'd12;
	localparam logic [3:0] S_PR_DEM = 4'd13;
	localparam logic [3:0] S_PR_SEL = 4'd14;
	localparam logic [3:0] S_OUT = 4'd15;

	logic [3:0] state_q, state_n;
	logic [IDX_W-1:0] i_q, i_n;
	logic [IDX_W-1:0] k_q, k_n;
	logic ctx_q, ctx_n;
	logic i_last, k_last;
	logic [CNT_W-1:0] i_inc;
	logic [3:0] after_wake;
	logic [1:0] start_addr;

	assign i_last = ({1'b0, i_q} == (st.n - 1'b1));
	assign k_last = ({1'b0, k_q} == (st.n - 1'b1));
	assign i_inc = {1'b0, i_q} + 1'b1;
	assign start_addr = ctx_q ? ADDR_SCAN : ADDR_TGT;

	// Where the tick goes once the wake pass is over
	always_comb begin
		case (st.mode)
			MODE_RR:   after_wake = S_RR_CHK;
			MODE_PRIO: after_wake = S_PR_SCAN;
			MODE_EDF:  after_wake = S_PR_SCAN;
			default:   after_wake = S_OUT;
		endcase
	end

	// Next state and datapath commands
	always_comb begin
		state_n = state_q;
		i_n = i_q;
		k_n = k_q;
		ctx_n = ctx_q;
		in_ready = 1'b0;
		ctl = '0;
		ctl.op = OP_NONE;
		ctl.addr_sel = ADDR_TGT;
		ctl.scan_idx = i_q;
		ctl.cv_sel = CV_DUR;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.latch = 1'b1;
					state_n = S_DISP;
				end
			end
			S_DISP: begin
				ctl.op = OP_DISP;
				if (st.is_start_ok) begin
					ctx_n = 1'b0;
					state_n = S_DL;
				end else if (st.tick_go) begin
					i_n = '0;
					state_n = S_WAKE;
				end else if (st.sleep_go) begin
					ctl.cv_start = 1'b1;
					ctl.cv_sel = CV_DUR;
					state_n = S_SLP_W;
				end else begin
					state_n = S_OUT;
				end
			end
			S_WAKE: begin
				ctl.op = OP_WAKE;
				ctl.addr_sel = ADDR_SCAN;
				if (st.start_hit) begin
					ctx_n = 1'b1;
					state_n = S_DL;
				end else if (i_last) begin
					i_n = '0;
					state_n = after_wake;
				end else begin
					i_n = i_inc[IDX_W-1:0];
				end
			end
			S_DL: begin
				ctl.addr_sel = start_addr;
				if (st.dl_neg) begin
					ctl.op = OP_ST_DL;
					state_n = S_PER;
				end else begin
					ctl.cv_start = 1'b1;
					ctl.cv_sel = CV_DL;
					state_n = S_DL_W;
				end
			end
			S_DL_W: begin
				ctl.addr_sel = start_addr;
				if (st.cv_done) begin
					ctl.op = OP_ST_DL;
					state_n = S_PER;
				end
			end
			S_PER: begin
				ctl.addr_sel = start_addr;
				ctl.cv_start = 1'b1;
				ctl.cv_sel = CV_PER;
				state_n = S_PER_W;
			end
			S_PER_W: begin
				ctl.addr_sel = start_addr;
				if (st.cv_done) begin
					ctl.op = OP_ST_PER;
					state_n = S_FIN;
				end
			end
			S_FIN: begin
				ctl.addr_sel = start_addr;
				ctl.op = OP_ST_FIN;
				if (!ctx_q) begin
					state_n = S_OUT;
				end else if (i_last) begin
					i_n = '0;
					state_n = after_wake;
				end else begin
					i_n = i_inc[IDX_W-1:0];
					state_n = S_WAKE;
				end
			end
			S_SLP_W: begin
				ctl.addr_sel = ADDR_CUR;
				if (st.cv_done) begin
					ctl.op = OP_SLEEP;
					state_n = S_OUT;
				end
			end
			S_RR_CHK: begin
				ctl.addr_sel = ADDR_CUR;
				ctl.op = OP_RR_CHK;
				if (st.rr_need) begin
					i_n = st.rr_j0;
					k_n = '0;
					state_n = S_RR_SCAN;
				end else begin
					state_n = S_OUT;
				end
			end
			S_RR_SCAN: begin
				ctl.addr_sel = ADDR_SCAN;
				ctl.op = OP_RR_PICK;
				if (st.rr_ready) begin
					state_n = S_OUT;
				end else if (k_last) begin
					state_n = S_RR_FALL;
				end else begin
					k_n = k_q + 1'b1;
					i_n = (i_inc == st.n) ? '0 : i_inc[IDX_W-1:0];
				end
			end
			S_RR_FALL: begin
				ctl.addr_sel = ADDR_CUR;
				ctl.op = OP_RR_FALL;
				state_n = S_OUT;
			end
			S_PR_SCAN: begin
				ctl.addr_sel = ADDR_SCAN;
				ctl.op = OP_PR_EVAL;
				ctl.first = (i_q == '0);
				if (i_last)
					state_n = S_PR_DEM;
				else
					i_n = i_inc[IDX_W-1:0];
			end
			S_PR_DEM: begin
				ctl.addr_sel = ADDR_CUR;
				ctl.op = OP_PR_DEM;
				state_n = S_PR_SEL;
			end
			S_PR_SEL: begin
				ctl.addr_sel = ADDR_BEST;
				ctl.op = OP_PR_SEL;
				state_n = S_OUT;
			end
			S_OUT: begin
				ctl.op = OP_OUT;
				if (st.out_free)
					state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q <= '0;
			k_q <= '0;
			ctx_q <= 1'b0;
		end else begin
			state_q <= state_n;
			i_q <= i_n;
			k_q <= k_n;
			ctx_q <= ctx_n;
		end
	end

`ifndef ASSERT_OFF
	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DISP))
		else $error("accepted word not dispatched");
	a_conv_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DL_W && !st.cv_done) |=> (state_q == S_DL_W))
		else $error("left deadline conversion before done");
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAKE || state_q == S_PR_SCAN) |-> ({1'b0, i_q} < st.n))
		else $error("scan index beyond thread count");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !st.out_free) |=> (state_q == S_OUT))
		else $error("result dropped while output full");
`endif

endmodule

@@ sv/task_scheduler_rr_priority_edf.sv @@
// Top level of the hardware thread scheduler.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    cmd, tid, now, priority_req, rel_dl_ms,
//                                             restart_ms, run_limit, duration_ms
//  out      output     out_valid / out_ready  running_valid, running_thread, switched,
//                                             accepted, thread_status
//  cfg      input      cfg_we                 cfg_index, cfg_data
//
// One word at a time. Configure, suspend, kill, yield, exit and rejected commands go
// from dispatch to the output; sleep converts its duration, start its deadline (unless
// none) and restart period; each ms-to-tick conversion is a product step and three
// 16-bit quotient digits by reciprocal multiply. A tick runs a wake pass, restarting each
// due periodic thread, then a selection scan over the table's single access port. Reset
// clears the table to its initial values at once. The result sits in an output register;
// a stalled output holds the controller before it takes the next word.
module task_scheduler_rr_priority_edf
	import tsch_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [3:0]  tid,
	input  logic [63:0] now,
	input  logic [7:0]  priority_req,
	input  logic signed [16:0] rel_dl_ms,
	input  logic [15:0] restart_ms,
	input  logic signed [16:0] run_limit,
	input  logic [15:0] duration_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        running_valid,
	output logic [3:0]  running_thread,
	output logic        switched,
	output logic        accepted,
	output logic [2:0]  thread_status
);

	ctl_t ctl;
	stat_t st;

	tsch_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.ctl      (ctl)
	);

	tsch_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.tid            (tid),
		.now            (now),
		.priority_req   (priority_req),
		.rel_dl_ms      (rel_dl_ms),
		.restart_ms     (restart_ms),
		.run_limit      (run_limit),
		.duration_ms    (duration_ms),
		.ctl            (ctl),
		.st             (st),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.running_valid  (running_valid),
		.running_thread (running_thread),
		.switched       (switched),
		.accepted       (accepted),
		.thread_status  (thread_status)
	);

endmodule

@@ dv/task_scheduler_rr_priority_edf_tb.sv @@
// Self-checking testbench for the thread scheduler: command words in, one status word out.
module task_scheduler_rr_priority_edf_tb;
	import tsch_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] cmd = '0;
	logic [3:0] tid = '0;
	logic [63:0] now = '0;
	logic [7:0] priority_req = '0;
	logic signed [16:0] rel_dl_ms = '0;
	logic [15:0] restart_ms = '0;
	logic signed [16:0] run_limit = '0;
	logic [15:0] duration_ms = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic running_valid;
	logic [3:0] running_thread;
	logic switched;
	logic accepted;
	logic [2:0] thread_status;

	task_scheduler_rr_priority_edf dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	typedef struct packed {
		logic rv;
		logic [3:0] rt;
		logic sw;
		logic acc;
		logic [2:0] st;
	} status_word_t;

	// Scheduler mirror
	logic en_m;
	logic [1:0] mode_m;
	logic [63:0] quant_m, freq_m;
	logic [4:0] count_m;
	logic [2:0] tstate [SLOTS];
	logic [7:0] tprio [SLOTS];
	int dl_off [SLOTS];
	int per_len [SLOTS];
	int tgt [SLOTS];
	int runs [SLOTS];
	logic [63:0] wake_at [SLOTS];
	logic [63:0] next_per [SLOTS];
	logic [63:0] abs_dl [SLOTS];
	int cur_idx;
	bit cur_ok;
	logic [63:0] slice_t0;

	status_word_t status_q[$];
	int errors = 0;
	int send_idle = 0, recv_stall = 0;

	function automatic logic [63:0] ms_to_ticks(int ms);
		logic [127:0] p;
		p = freq_m * 64'(ms);
		return 64'(p / 1000);
	endfunction

	function automatic void mirror_start(int i, logic [63:0] t);
		abs_dl[i] = (dl_off[i] < 0) ? '1 : t + ms_to_ticks(dl_off[i]);
		next_per[i] = t + ms_to_ticks(per_len[i]);
		if ((tstate[i] == ST_NEW || tstate[i] == ST_TERM) && runs[i] < 65535)
			runs[i]++;
		tstate[i] = ST_READY;
	endfunction

	function automatic void mirror_tick(logic [63:0] t, int n);
		bit need, found;
		int base, j, best;
		for (int i = 0; i < n; i++) begin
			if (tstate[i] == ST_BLOCKED) begin
				if (t >= wake_at[i]) tstate[i] = ST_READY;
			end else if ((tstate[i] == ST_TERM || tstate[i] == ST_NEW) &&
					!(cur_ok && cur_idx == i)) begin
				if ((tgt[i] == -1 || runs[i] < tgt[i]) && t >= next_per[i])
					mirror_start(i, t);
			end
		end
		if (mode_m == MODE_RR) begin
			need = 0;
			if (!cur_ok || tstate[cur_idx] != ST_RUN) need = 1;
			else if (t - slice_t0 >= quant_m) begin
				need = 1;
				tstate[cur_idx] = ST_READY;
			end
			if (need) begin
				base = (cur_ok && cur_idx < n) ? cur_idx : n - 1;
				for (int k = 1; k <= n; k++) begin
					j = (base + k) % n;
					if (tstate[j] == ST_READY) begin
						cur_idx = j;
						cur_ok = 1;
						tstate[j] = ST_RUN;
						slice_t0 = t;
						return;
					end
				end
				if (cur_ok && tstate[cur_idx] == ST_READY) begin
					tstate[cur_idx] = ST_RUN;
					slice_t0 = t;
				end
			end
		end else if (mode_m == MODE_PRIO || mode_m == MODE_EDF) begin
			found = 0;
			best = 0;
			for (int i = 0; i < n; i++) begin
				if (tstate[i] != ST_READY && tstate[i] != ST_RUN) continue;
				if (!found) begin
					found = 1;
					best = i;
				end else if (mode_m == MODE_PRIO) begin
					if (tprio[i] < tprio[best]) best = i;
				end else if (abs_dl[i] < abs_dl[best]) best = i;
			end
			if (found) begin
				if (!(cur_ok && cur_idx == best)) begin
					if (cur_ok && tstate[cur_idx] == ST_RUN) tstate[cur_idx] = ST_READY;
					cur_idx = best;
					cur_ok = 1;
				end
				tstate[best] = ST_RUN;
			end
		end
	endfunction

	// Expected status word for one command word
	function automatic status_word_t predict_status(logic [2:0] c, logic [3:0] id,
			logic [63:0] t, logic [7:0] pr, logic signed [16:0] dl, logic [15:0] per,
			logic signed [16:0] tg, logic [15:0] dur);
		status_word_t r;
		int n;
		bit old_ok, by_id;
		int old_idx;
		n = (count_m > SLOTS) ? SLOTS : count_m;
		old_ok = cur_ok;
		old_idx = cur_idx;
		by_id = (c >= CMD_CONF && c <= CMD_KILL);
		r = '0;
		if (by_id) begin
			if (id < n) begin
				r.acc = 1;
				case (c)
					CMD_CONF: begin
						tprio[id] = pr;
						dl_off[id] = int'(dl);
						per_len[id] = per;
						tgt[id] = int'(tg);
						runs[id] = 0;
					end
					CMD_START: mirror_start(id, t);
					CMD_SUSP: tstate[id] = (tstate[id] == ST_BLOCKED) ? ST_SUSP_WAIT : ST_SUSP_READY;
					default: begin
						tgt[id] = 0;
						runs[id] = 0;
						tstate[id] = ST_TERM;
					end
				endcase
				r.st = tstate[id];
			end
		end else if (c == CMD_TICK) begin
			if (n != 0 && en_m) begin
				r.acc = 1;
				mirror_tick(t, n);
			end
		end else if (cur_ok) begin
			if (c == CMD_SLEEP) begin
				if (en_m) begin
					r.acc = 1;
					wake_at[cur_idx] = t + ms_to_ticks(dur);
					tstate[cur_idx] = ST_BLOCKED;
				end
			end else if (c == CMD_YIELD) begin
				r.acc = 1;
				if (tstate[cur_idx] == ST_RUN) tstate[cur_idx] = ST_READY;
			end else begin
				r.acc = 1;
				tstate[cur_idx] = ST_TERM;
			end
		end
		if (!by_id && cur_ok) r.st = tstate[cur_idx];
		r.rv = cur_ok;
		r.rt = cur_ok ? 4'(cur_idx) : '0;
		r.sw = (cur_ok != old_ok) || (cur_ok && cur_idx != old_idx);
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Status word checker
	always @(posedge clk) begin
		status_word_t e;
		if (out_valid && out_ready) begin
			if (status_q.size() == 0) report_mismatch("unexpected word", 1, 0);
			else begin
				e = status_q.pop_front();
				if (running_valid !== e.rv) report_mismatch("running_valid", running_valid, e.rv);
				if (running_thread !== e.rt)
					report_mismatch("running_thread", running_thread, e.rt);
				if (switched !== e.sw) report_mismatch("switched", switched, e.sw);
				if (accepted !== e.acc) report_mismatch("accepted", accepted, e.acc);
				if (thread_status !== e.st)
					report_mismatch("thread_status", thread_status, e.st);
			end
		end
	end

	// Receiver stall
	always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall);

	logic [63:0] clock_now = 64'd1000;

	// Drives one word from the edge after the previous one was taken, or later when idle cycles are drawn
	task automatic send_word(logic [2:0] c, logic [3:0] id, logic [63:0] t,
			logic [7:0] pr = 0, logic signed [16:0] dl = -1, logic [15:0] per = 0,
			logic signed [16:0] tg = -1, logic [15:0] dur = 0);
		do @(posedge clk); while ($urandom_range(99) < send_idle);
		status_q.push_back(predict_status(c, id, t, pr, dl, per, tg, dur));
		in_valid <= 1'b1;
		cmd <= c;
		tid <= id;
		now <= t;
		priority_req <= pr;
		rel_dl_ms <= dl;
		restart_ms <= per;
		run_limit <= tg;
		duration_ms <= dur;
		do @(posedge clk); while (!in_ready);
		in_valid <= 1'b0;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		case (idx)
			CFG_EN: en_m = val[0];
			CFG_MODE: mode_m = val[1:0];
			CFG_QUANT: quant_m = val;
			CFG_FREQ: freq_m = val;
			CFG_COUNT: count_m = val[4:0];
			default: ;
		endcase
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain_words();
		while (status_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Random word, biased to ticks, small field values and forward time
	task automatic send_random_word();
		logic [2:0] c;
		logic signed [16:0] dl, tg;
		c = ($urandom_range(99) < 35) ? CMD_TICK : 3'($urandom_range(7));
		clock_now += $urandom_range(3) == 0 ? 64'($urandom) : 64'($urandom_range(200000));
		dl = ($urandom_range(3) == 0) ? 17'($urandom) : 17'($urandom_range(50));
		tg = ($urandom_range(3) == 0) ? 17'($urandom) : 17'($urandom_range(6)) - 17'd1;
		send_word(c, 4'($urandom_range(15)), clock_now, 8'($urandom),
			dl, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20)),
			tg, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20)));
	endtask

	task automatic test_idle_block();
		send_word(CMD_TICK, 0, 0);
		send_word(CMD_YIELD, 0, 5);
		send_word(CMD_START, 0, 5);
		drain_words();
	endtask

	task automatic test_directed();
		write_reg(CFG_COUNT, 31);
		write_reg(CFG_EN, 1);
		write_reg(CFG_MODE, MODE_RR);
		write_reg(CFG_QUANT, 0);
		write_reg(CFG_FREQ, 0);
		send_word(CMD_SLEEP, 0, 1, 0, -1, 0, -1, 16'hFFFF);
		send_word(CMD_CONF, 15, 0, 8'hFF, 17'sd65535, 16'hFFFF, 17'sd65535);
		send_word(CMD_CONF, 0, 0, 8'h00, -17'sd65536, 0, -17'sd2);
		send_word(CMD_START, 0, '1);
		send_word(CMD_START, 15, 64'hFFFF_FFFF_FFFF_FFF0);
		send_word(CMD_TICK, 0, 10);
		send_word(CMD_TICK, 0, 11);
		send_word(CMD_SUSP, 0, 12);
		send_word(CMD_TICK, 0, 13);
		send_word(CMD_SLEEP, 0, 14, 0, -1, 0, -1, 16'hFFFF);
		send_word(CMD_YIELD, 0, 15);
		send_word(CMD_EXIT, 0, 16);
		send_word(CMD_KILL, 15, 17);
		send_word(CMD_TICK, 0, 18);
		drain_words();
		write_reg(CFG_FREQ, 32'hFFFF_FFFF);
		write_reg(CFG_QUANT, 32'hFFFF_FFFF);
		write_reg(CFG_MODE, 3);
		write_reg(CFG_COUNT, 2);
		send_word(CMD_START, 1, 20, 0, 17'sd100, 0, -1);
		send_word(CMD_TICK, 0, 21);
		send_word(CMD_CONF, 3, 22);
		drain_words();
		write_reg(CFG_EN, 0);
		send_word(CMD_TICK, 0, 23);
		send_word(CMD_SLEEP, 0, 24, 0, -1, 0, -1, 5);
		drain_words();
	endtask

	task automatic test_random_phase(int n_words, int idle, int stall);
		logic [31:0] m;
		send_idle = idle;
		recv_stall = stall;
		m = 32'($urandom_range(2));
		write_reg(CFG_MODE, m);
		write_reg(CFG_EN, ($urandom_range(9) != 0));
		write_reg(CFG_COUNT, $urandom_range(1, 16));
		write_reg(CFG_FREQ, ($urandom_range(1)) ? 1000 : $urandom_range(1, 24000000));
		write_reg(CFG_QUANT, $urandom_range(0, 300000));
		for (int i = 0; i < n_words; i++) send_random_word();
		drain_words();
	endtask

	initial begin
		en_m = 0; mode_m = 0; quant_m = 480000; freq_m = 24000000; count_m = 0;
		for (int i = 0; i < SLOTS; i++) begin
			tstate[i] = ST_NEW; tprio[i] = 128; dl_off[i] = -1; per_len[i] = 0;
			tgt[i] = 0; runs[i] = 0; wake_at[i] = 0; next_per[i] = 0; abs_dl[i] = 0;
		end
		cur_idx = 0; cur_ok = 0; slice_t0 = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_block();
		test_directed();
		test_random_phase(120, 0, 0);
		test_random_phase(110, 69, 0);
		test_random_phase(110, 0, 69);
		test_random_phase(110, 27, 27);
		if (errors == 0)
			$display("task_scheduler_rr_priority_edf_tb: done, clean");
		else
			$display("task_scheduler_rr_priority_edf_tb: done, errors");
		$finish;
	end

	// Run limit
	initial begin
		#20000000;
		$display("task_scheduler_rr_priority_edf_tb: done, errors");
		$finish;
	end
endmodule
